// File: hdl/dsa_pkg.sv
// ---------------------------------------------------------------------------
// dsa_pkg: shared types and constants for the descriptor slot allocator
// Codes for operations, status, registers, and controller/datapath links.
// ---------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned HeapDepthDef  = 1024;
  localparam int unsigned FrameCountDef = 3;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_PROCESS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NULL    = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_QUEUE   = 3'd4;

  localparam logic [2:0] REG_SLOTS  = 3'd0;
  localparam logic [2:0] REG_STRIDE = 3'd1;
  localparam logic [2:0] REG_CPU    = 3'd2;
  localparam logic [2:0] REG_GPU    = 3'd3;
  localparam logic [2:0] REG_VIS    = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic early_fin;  // finish an item decided at decode
    logic div_start;  // start address divide
    logic alloc_rd;   // issue free-table read at used count
    logic alloc_fin;  // finish allocate (multiply done)
    logic mul_step;   // multiply step
    logic free_fin;   // commit free
    logic drain_wr;   // push entry back to free table
    logic drain_fin;  // finish process
    logic clr_step;   // write one free-table init entry
    logic out_load;   // present result
  } dsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       div_done;
    logic       mul_done;
    logic       drain_last;
    logic       drain_under;
    logic       clr_done;
    logic       early;      // result known at decode without further work
  } dsa_sts_t;

endpackage

// File: hdl/dsa_ram.sv
// ---------------------------------------------------------------------------
// dsa_ram: generic single-port-write, one-read RAM
// Registered read data.
// ---------------------------------------------------------------------------
module dsa_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/dsa_ctrl.sv
// ---------------------------------------------------------------------------
// dsa_ctrl: sequencer of the descriptor slot allocator
// Steps clear, allocate, free and process work through the datapath.
// ---------------------------------------------------------------------------
module dsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dsa_pkg::dsa_cmd_t cmd,
  input  dsa_pkg::dsa_sts_t sts
);
  import dsa_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_AMUL  = 4'd4;
  localparam logic [3:0] S_FDIV  = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_DWAIT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign out_tvalid = ovalid_r;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.early) begin
          cmd.early_fin = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.op == OP_ALLOC) begin
          cmd.alloc_rd = 1'b1;
          state_nxt    = S_ARD;
        end else if (sts.op == OP_FREE) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_FDIV;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_ARD: begin
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        if (sts.mul_done) begin
          cmd.alloc_fin = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_FDIV: begin
        if (sts.div_done) begin
          cmd.free_fin = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DRD: begin
        if (sts.drain_last || sts.drain_under) begin
          cmd.drain_fin = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        state_nxt = S_DWR;
      end
      S_DWR: begin
        cmd.drain_wr = 1'b1;
        state_nxt    = S_DRD;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Nothing accepted during the clearing sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("item accepted during clear");
  // A result is never overwritten while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.out_load)
    else $error("result overwritten");
  // Load only from idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DEC))
    else $error("load did not decode");
endmodule

// File: hdl/dsa_dp.sv
// ---------------------------------------------------------------------------
// dsa_dp: datapath of the descriptor slot allocator
// Free table, deferred queues, registers, serial divider and multiplier.
// ---------------------------------------------------------------------------
module dsa_dp #(
  parameter int unsigned HeapDepth  = dsa_pkg::HeapDepthDef,
  parameter int unsigned FrameCount = dsa_pkg::FrameCountDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata,
  input  logic [67:0]       in_word,
  input  dsa_pkg::dsa_cmd_t cmd,
  output dsa_pkg::dsa_sts_t sts,
  output logic [143:0]      out_word
);
  import dsa_pkg::*;

  localparam int unsigned AW  = $clog2(HeapDepth);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned FW  = (FrameCount > 1) ? $clog2(FrameCount) : 1;
  localparam int unsigned QD  = HeapDepth * FrameCount;
  localparam int unsigned QAW = $clog2(QD);

  // Configuration registers
  logic [10:0] slots_r;
  logic [12:0] stride_r;
  logic [63:0] cpu_base_r, gpu_base_r;
  logic        vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r    <= 11'd1024;
      stride_r   <= 13'd32;
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      vis_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOTS:  slots_r    <= cfg_wdata[10:0];
        REG_STRIDE: stride_r   <= cfg_wdata[12:0];
        REG_CPU:    cpu_base_r <= cfg_wdata;
        REG_GPU:    gpu_base_r <= cfg_wdata;
        REG_VIS:    vis_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Usable count: min(configured slots, depth)
  logic [CW:0] usable;
  always_comb begin
    if ({{(CW+1 > 11 ? CW+1-11 : 0){1'b0}}, slots_r} < (CW+1 > 11 ? CW+1 : 11)'(HeapDepth))
      usable = (CW+1)'(slots_r);
    else
      usable = (CW+1)'(HeapDepth);
  end

  // Captured item
  logic [1:0]  op_r;
  logic [1:0]  frame_r;
  logic [63:0] addr_r;
  logic [63:0] diff_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_word[1:0];
      frame_r <= in_word[3:2];
      addr_r  <= in_word[67:4];
      diff_r  <= in_word[67:4] - cpu_base_r;
    end
  end

  // Counters
  logic [CW-1:0] used_r;
  logic [CW-1:0] dcnt_r [FrameCount];
  logic [CW-1:0] clr_r;
  logic [CW-1:0] di_r;     // drain position
  logic          frame_ok;
  logic [FW-1:0] fidx;
  logic [CW-1:0] fcnt;

  assign frame_ok = {2'b00, frame_r} < 4'(FrameCount);
  assign fidx     = FW'(frame_r);
  assign fcnt     = frame_ok ? dcnt_r[fidx] : '0;

  // Early decision at decode
  logic [2:0] early_st;
  logic       early;
  always_comb begin
    early    = 1'b0;
    early_st = ST_OK;
    case (op_r)
      OP_ALLOC: begin
        if ({1'b0, used_r} >= usable) begin
          early = 1'b1; early_st = ST_FULL;
        end
      end
      OP_FREE: begin
        if (addr_r == '0) begin
          early = 1'b1; early_st = ST_NULL;
        end else if (addr_r < cpu_base_r || stride_r == '0) begin
          early = 1'b1; early_st = ST_BADADDR;
        end
      end
      OP_PROCESS: begin
        if (!frame_ok) begin
          early = 1'b1; early_st = ST_QUEUE;
        end
      end
      default: early = 1'b1;
    endcase
  end

  // Serial restoring divider: diff / stride, one quotient bit a cycle
  logic [63:0] quo_r;
  logic [12:0] rem_r;
  logic [6:0]  dcyc_r;
  logic        dbusy_r;
  logic [13:0] trial;
  assign trial = {rem_r, quo_r[63]} - {1'b0, stride_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      quo_r   <= diff_r;
      rem_r   <= '0;
      dcyc_r  <= 7'd0;
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      if (!trial[13]) begin
        rem_r <= trial[12:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[11:0], quo_r[63]};
        quo_r <= {quo_r[62:0], 1'b0};
      end
      dcyc_r <= dcyc_r + 7'd1;
      if (dcyc_r == 7'd63) begin
        dbusy_r <= 1'b0;
      end
    end
  end
  logic div_done;
  assign div_done = !dbusy_r && !cmd.div_start;

  // Free table and deferred queue memories
  logic          ft_we;
  logic [AW-1:0] ft_waddr, ft_raddr;
  logic [AW-1:0] ft_wdata, ft_rdata;
  logic          q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [AW-1:0] q_rdata;

  dsa_ram #(.Width(AW), .Depth(HeapDepth)) u_ft (
    .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
    .raddr(ft_raddr), .rdata(ft_rdata)
  );
  dsa_ram #(.Width(AW), .Depth(QD)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(quo_r[AW-1:0]),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Free check after divide
  logic free_ok;
  logic [2:0] free_st;
  always_comb begin
    free_ok = 1'b0;
    free_st = ST_BADADDR;
    if (rem_r != '0 || quo_r >= 64'(usable)) begin
      free_st = ST_BADADDR;
    end else if (used_r == '0 || !frame_ok || fcnt >= CW'(HeapDepth)) begin
      free_st = ST_QUEUE;
    end else begin
      free_ok = 1'b1;
      free_st = ST_OK;
    end
  end

  assign q_we    = cmd.free_fin && free_ok;
  assign q_waddr = QAW'(fidx * HeapDepth + fcnt[AW-1:0]);
  assign q_raddr = QAW'(fidx * HeapDepth + di_r[AW-1:0]);

  assign ft_raddr = used_r[AW-1:0];
  always_comb begin
    ft_we    = cmd.clr_step || cmd.drain_wr;
    ft_waddr = cmd.clr_step ? clr_r[AW-1:0] : AW'(used_r - CW'(1));
    ft_wdata = cmd.clr_step ? clr_r[AW-1:0] : q_rdata;
  end

  // Serial multiplier: index * stride, shift-add over stride bits
  logic [AW-1:0] idx_r;
  logic [63:0]   prod_r;
  logic [3:0]    mcyc_r;
  always_ff @(posedge clk) begin
    if (cmd.alloc_rd) begin
      prod_r <= '0;
      mcyc_r <= 4'd0;
    end else if (cmd.mul_step) begin
      if (mcyc_r == 4'd0) begin
        idx_r <= ft_rdata;
      end
      if (mcyc_r != 4'd0 && stride_r[4'd13 - mcyc_r]) begin
        prod_r <= (prod_r << 1) + 64'(idx_r);
      end else if (mcyc_r != 4'd0) begin
        prod_r <= prod_r << 1;
      end
      mcyc_r <= mcyc_r + 4'd1;
    end
  end
  logic mul_done;
  assign mul_done = (mcyc_r == 4'd14) && !cmd.alloc_rd;

  // Counter updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      clr_r  <= '0;
      di_r   <= '0;
      for (int f = 0; f < FrameCount; f++) begin
        dcnt_r[f] <= '0;
      end
    end else begin
      if (cmd.clr_step && clr_r != CW'(HeapDepth)) begin
        clr_r <= clr_r + CW'(1);
      end
      if (cmd.load) begin
        di_r <= '0;
      end
      if (cmd.alloc_fin) begin
        used_r <= used_r + CW'(1);
      end
      if (q_we) begin
        dcnt_r[fidx] <= fcnt + CW'(1);
      end
      if (cmd.drain_wr) begin
        used_r <= used_r - CW'(1);
        di_r   <= di_r + CW'(1);
      end
      if (cmd.drain_fin) begin
        dcnt_r[fidx] <= '0;
      end
    end
  end

  // Result register
  logic [2:0]    rst_st_r;
  logic [AW-1:0] ridx_r;
  logic [63:0]   rca_r, rga_r;
  logic [2:0]    res_st_r;
  logic          under;
  assign under = (di_r < fcnt) && (used_r == '0);
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_st_r <= ST_OK;
      ridx_r   <= '0;
      rca_r    <= '0;
      rga_r    <= '0;
    end
    if (cmd.early_fin) begin
      res_st_r <= early_st;
    end
    if (cmd.alloc_fin) begin
      res_st_r <= ST_OK;
      ridx_r   <= idx_r;
      rca_r    <= cpu_base_r + prod_r;
      rga_r    <= vis_r ? gpu_base_r + prod_r : '0;
    end
    if (cmd.free_fin) begin
      res_st_r <= free_st;
      ridx_r   <= free_ok ? quo_r[AW-1:0] : '0;
    end
    if (cmd.drain_fin) begin
      res_st_r <= under ? ST_QUEUE : ST_OK;
    end
    if (cmd.out_load) begin
      rst_st_r <= res_st_r;
    end
  end
  logic [AW-1:0] oidx_r;
  logic [63:0]   oca_r, oga_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oidx_r <= ridx_r;
      oca_r  <= rca_r;
      oga_r  <= rga_r;
    end
  end
  assign out_word = {3'b000, oga_r, oca_r, 10'(oidx_r), rst_st_r};

  assign sts.op          = op_r;
  assign sts.div_done    = div_done;
  assign sts.mul_done    = mul_done;
  assign sts.drain_last  = di_r >= fcnt;
  assign sts.drain_under = under;
  assign sts.clr_done    = clr_r == CW'(HeapDepth - 1) || clr_r == CW'(HeapDepth);
  assign sts.early       = early;

  // Used count never exceeds the built depth
  assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(HeapDepth))
    else $error("used count out of range");
  // A queue write never lands on a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> (fcnt < CW'(HeapDepth)))
    else $error("queue overflow write");
  // Drain writes never happen at zero used count
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_wr |-> (used_r != '0))
    else $error("drain underflow write");
endmodule

// File: hdl/descriptor_slot_allocator_core.sv
// ---------------------------------------------------------------------------
// descriptor_slot_allocator_core: free-list slot allocator, deferred free
// Stack of free slot indices with per-frame queues of released slots.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_     | in  | in_tvalid/tready  | tdata: operation, frame_slot, release_address
//  out_    | out | out_tvalid/tready | tdata: status, slot_index, cpu/gpu address
//  cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
// Allocate: a 13-step shift-add multiply forms the address.
// Free: a 64-step serial divide of the address offset.
// Process: per drained entry, a queue RAM read and a free-table write.
// After reset all HEAP_DEPTH entries of the free table are swept, one a cycle,
// before the first item is taken. A stalled result holds in the output
// register while the next item is taken; that item waits in its last step.
module descriptor_slot_allocator_core #(
  parameter int unsigned HEAP_DEPTH  = dsa_pkg::HeapDepthDef,
  parameter int unsigned FRAME_COUNT = dsa_pkg::FrameCountDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // operation[1:0], frame_slot[3:2], release_address[67:4]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // status[2:0], slot_index[12:3], cpu_address[76:13],
                                   // gpu_address[140:77]
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import dsa_pkg::*;

  dsa_cmd_t     cmd;
  dsa_sts_t     sts;
  logic [143:0] dp_word;

  dsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  dsa_dp #(.HeapDepth(HEAP_DEPTH), .FrameCount(FRAME_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_word(in_tdata[67:0]), .cmd(cmd), .sts(sts),
    .out_word(dp_word)
  );

  // Result fields arrive packed without gaps
  assign out_tdata = dp_word;
endmodule
